[design/bba_pkg.sv]
`default_nettype none
package bba_pkg;

  localparam int MAX_BLOCKS  = 1024;
  localparam int WORD_BITS   = 32;
  localparam int WORDS       = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int BLK_W       = 10;
  localparam int CNT_W       = 11;
  localparam int BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int WORD_IDX_W  = $clog2(WORDS);
  localparam int FULL_W      = CNT_W - BIT_IDX_W;
  localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = CNT_W'(MAX_BLOCKS);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [BLK_W-1:0] release_block;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [BLK_W-1:0] granted_block;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage
`default_nettype wire

[design/bitmap_block_allocator.sv]
// A free answers with done strobed the cycle after start; an allocate enters the
//   scan and checks one bitmap word per cycle until it finds a free bit or ends.
// One request in flight; a free is ready again the next cycle, an allocate holds
//   busy until its scan ends.
// Reset (rst, sync, active high): bitmap all free, block_count = 1024, idle.
// Results are strobed for one cycle on done; the receiver cannot stall.
`default_nettype none
module bitmap_block_allocator (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire bba_pkg::req_t            req,
  input  wire logic                     cfg_we,
  input  wire logic [bba_pkg::CNT_W-1:0] cfg_data,
  output logic                          done,
  output bba_pkg::rsp_t                 rsp
);
  import bba_pkg::*;

  // lowest set bit of a word
  function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (v[b]) idx = BIT_IDX_W'(b);
    end
    return idx;
  endfunction

  // usage bitmap: 1 = block in use
  logic [WORD_BITS-1:0]  bitmap [WORDS];
  logic [CNT_W-1:0]      block_count;
  state_t                state, state_next;
  logic [WORD_IDX_W-1:0] scan_idx, scan_idx_next;
  logic                  done_next;
  rsp_t                  rsp_next;

  // single shared word port
  logic                  wr_en;
  logic [WORD_IDX_W-1:0] wr_idx;
  logic [WORD_BITS-1:0]  wr_data;
  logic [WORD_IDX_W-1:0] rd_idx;
  logic [WORD_BITS-1:0]  rd_word;

  // effective count, saturated to the bitmap size
  logic [CNT_W-1:0]      eff_count;
  logic [FULL_W-1:0]     full_words;
  logic [BIT_IDX_W-1:0]  rem_bits;
  logic [WORD_BITS-1:0]  scan_mask;
  logic [WORD_BITS-1:0]  free_bits;
  logic [BIT_IDX_W-1:0]  hit_bit;
  logic                  last_word;
  logic [BIT_IDX_W-1:0]  req_bit;

  assign eff_count  = (block_count > BLOCK_COUNT_RESET) ? BLOCK_COUNT_RESET : block_count;
  assign full_words = eff_count[CNT_W-1:BIT_IDX_W];
  assign rem_bits   = eff_count[BIT_IDX_W-1:0];
  assign req_bit    = req.release_block[BIT_IDX_W-1:0];

  assign rd_idx  = (state == ST_IDLE) ? req.release_block[BLK_W-1:BIT_IDX_W] : scan_idx;
  assign rd_word = bitmap[rd_idx];

  // bits of the scanned word that lie below the count
  always_comb begin
    if (FULL_W'(scan_idx) < full_words) begin
      scan_mask = '1;
    end else if (FULL_W'(scan_idx) == full_words) begin
      scan_mask = ~({WORD_BITS{1'b1}} << rem_bits);
    end else begin
      scan_mask = '0;
    end
  end

  assign free_bits = ~rd_word & scan_mask;
  assign hit_bit   = lowest_set(free_bits);
  // nothing managed past the partially covered word
  assign last_word = (scan_idx == WORD_IDX_W'(WORDS - 1)) ||
                     (FULL_W'(scan_idx) >= full_words);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      scan_idx    <= '0;
      done        <= 1'b0;
      block_count <= BLOCK_COUNT_RESET;
      for (int w = 0; w < WORDS; w++) bitmap[w] <= '0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
      done     <= done_next;
      if (cfg_we) block_count <= cfg_data;
      if (wr_en) bitmap[wr_idx] <= wr_data;
    end
  end

  // result payload, qualified by done
  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    done_next     = 1'b0;
    rsp_next      = rsp;
    wr_en         = 1'b0;
    wr_idx        = rd_idx;
    wr_data       = rd_word;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (req.opcode == OP_FREE) begin
            done_next = 1'b1;
            rsp_next  = '0;
            // frees at or past the count are dropped
            if ({1'b0, req.release_block} < eff_count) begin
              wr_en   = 1'b1;
              wr_data = rd_word & ~(WORD_BITS'(1) << req_bit);
            end
          end else begin
            state_next    = ST_SCAN;
            scan_idx_next = '0;
          end
        end
      end
      ST_SCAN: begin
        if (|free_bits) begin
          wr_en                  = 1'b1;
          wr_data                = rd_word | (WORD_BITS'(1) << hit_bit);
          done_next              = 1'b1;
          rsp_next.found         = 1'b1;
          rsp_next.granted_block = BLK_W'({scan_idx, hit_bit});
          state_next             = ST_IDLE;
        end else if (last_word) begin
          done_next  = 1'b1;
          rsp_next   = '0;
          state_next = ST_IDLE;
        end else begin
          scan_idx_next = scan_idx + WORD_IDX_W'(1);
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule
`default_nettype wire

[design/bba_checker.sv]
`default_nettype none
module bba_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      start,
  input wire logic                      busy,
  input wire bba_pkg::req_t             req,
  input wire logic                      cfg_we,
  input wire logic [bba_pkg::CNT_W-1:0] cfg_data,
  input wire logic                      done,
  input wire bba_pkg::rsp_t             rsp
);
  import bba_pkg::*;

  // free answers in the next cycle, never with a grant
  a_free_resp: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.opcode == OP_FREE) |=> (done && !rsp.found))
    else $error("free request did not answer next cycle");

  // allocate enters the scan, no beat in the first cycle
  a_alloc_scan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.opcode == OP_ALLOC) |=> (busy && !done))
    else $error("allocate did not start scanning");

  // a beat is only shown once the sequencer is idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  a_nogrant_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.found) |-> (rsp.granted_block == '0))
    else $error("failed result carries a block number");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("not idle after reset");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .req      (req),
  .cfg_we   (cfg_we),
  .cfg_data (cfg_data),
  .done     (done),
  .rsp      (rsp)
);
`default_nettype wire

[tb/sv/bitmap_block_allocator_test.sv]
`timescale 1ns / 100ps
module bitmap_block_allocator_test;
  import bba_pkg::*;

  // Cycles with no beat of any kind before the run is declared hung. The slowest
  // legal wait is one sender gap plus a full 32-word scan, so this is ample.
  localparam int STALL_LIMIT = 4000;
  // Quiet time at the end: one worst-case allocate scan plus margin.
  localparam int TAIL_CYCLES = 40;

  // Kinds of work the driver pulls from its queue.
  typedef enum logic [1:0] {
    ITEM_REQ,
    ITEM_COUNT,
    ITEM_DRAIN
  } item_kind_t;

  typedef struct packed {
    item_kind_t       kind;
    req_t             req;
    logic [CNT_W-1:0] count;
    logic [7:0]       pause;
  } pending_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  req_t             req = '0;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic             busy;
  logic             done;
  rsp_t             rsp;

  bitmap_block_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  // Testbench copy of the frame map and the managed block count.
  logic [MAX_BLOCKS-1:0] frame_used = '0;
  logic [CNT_W-1:0]      managed_count = BLOCK_COUNT_RESET;

  pending_t pending[$];
  rsp_t     expected_grants[$];
  int       inflight = 0;     // requests accepted whose result has not come
  int       idle_cycles = 0;  // gap already served before the head item
  int       err_count = 0;

  // Sender burst shaping, used while the stimulus queue is filled.
  int       burst_left = 0;
  bit       calm = 0;         // phase with no gaps at all
  int       requests_queued = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    err_count++;
  endtask

  // First fit over the blocks below the saturated count; a free clears one bit
  // if it lies below that count. Every request yields exactly one result.
  function automatic rsp_t predict_grant(input req_t r);
    rsp_t        res;
    int unsigned lim;
    int unsigned b;
    res = '0;
    lim = (managed_count > MAX_BLOCKS) ? MAX_BLOCKS : managed_count;
    if (r.opcode == OP_ALLOC) begin
      for (b = 0; b < lim && !res.found; b++) begin
        if (!frame_used[b]) begin
          frame_used[b]     = 1'b1;
          res.found         = 1'b1;
          res.granted_block = BLK_W'(b);
        end
      end
    end else if (r.release_block < lim) begin
      frame_used[r.release_block] = 1'b0;
    end
    return res;
  endfunction

  task automatic queue_request(input opcode_t op, input logic [BLK_W-1:0] blk);
    pending_t p;
    p = '0;
    p.kind = ITEM_REQ;
    p.req.opcode = op;
    p.req.release_block = blk;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      p.pause = calm ? 8'd0 : 8'($urandom_range(1, 30));
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      p.pause = 8'($urandom_range(1, 3));
    end
    burst_left--;
    requests_queued++;
    pending.push_back(p);
  endtask

  // Count writes wait for the block to go idle inside the driver.
  task automatic queue_count(input logic [CNT_W-1:0] cnt);
    pending_t p;
    p = '0;
    p.kind = ITEM_COUNT;
    p.count = cnt;
    pending.push_back(p);
  endtask

  task automatic queue_drain();
    pending_t p;
    p = '0;
    p.kind = ITEM_DRAIN;
    pending.push_back(p);
  endtask

  // Driver: holds start until the beat is taken, then serves the next item's gap.
  // Count writes and drains only go out once nothing is in flight and busy is low.
  always @(posedge clk) begin : drive
    logic accepted;
    logic start_n;
    logic cfg_n;
    int   inflight_n;
    if (rst) begin
      start  <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      accepted   = start && !busy;
      start_n    = start && !accepted;
      cfg_n      = 1'b0;
      inflight_n = inflight + (accepted ? 1 : 0) - (done ? 1 : 0);
      if (accepted)
        expected_grants.push_back(predict_grant(req));
      if (!start_n && !cfg_we && pending.size() != 0) begin
        case (pending[0].kind)
          ITEM_REQ: begin
            if (idle_cycles < pending[0].pause) begin
              idle_cycles <= idle_cycles + 1;
            end else begin
              req         <= pending[0].req;
              start_n     = 1'b1;
              idle_cycles <= 0;
              void'(pending.pop_front());
            end
          end
          ITEM_COUNT: begin
            if (inflight_n == 0 && !busy) begin
              cfg_n         = 1'b1;
              cfg_data      <= pending[0].count;
              managed_count = pending[0].count;  // takes effect at the next edge
              void'(pending.pop_front());
            end
          end
          default: begin
            // hold-off: wait out every pending result
            if (inflight_n == 0 && !busy)
              void'(pending.pop_front());
          end
        endcase
      end
      start    <= start_n;
      cfg_we   <= cfg_n;
      inflight <= inflight_n;
    end
  end

  // Monitor: every done beat must match the oldest prediction.
  always @(posedge clk) begin : watch_results
    rsp_t want;
    if (!rst && done) begin
      if (expected_grants.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%0b block=%0d",
                                  rsp.found, rsp.granted_block));
      end else begin
        want = expected_grants.pop_front();
        if (rsp.found !== want.found)
          report_mismatch($sformatf("found: got %b want %b", rsp.found, want.found));
        if (rsp.granted_block !== want.granted_block)
          report_mismatch($sformatf("granted_block: got %0d want %0d",
                                    rsp.granted_block, want.granted_block));
      end
    end
  end

  // Watchdog on cycles without any beat.
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TIMEOUT after %0d quiet cycles", stall_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int          phase_len;
    int          alloc_pct;
    int unsigned lim;
    logic [CNT_W-1:0] cnt;

    // --- directed part ---
    calm = 1;
    queue_request(OP_ALLOC, 10'd0);        // 0
    queue_request(OP_ALLOC, 10'h3FF);      // 1, block field ignored on allocate
    queue_request(OP_ALLOC, 10'h2AA);      // 2
    queue_request(OP_FREE, 10'd1);
    queue_request(OP_ALLOC, 10'h155);      // hole at 1 refilled
    queue_request(OP_FREE, 10'h3FF);       // already free, top block
    queue_request(OP_FREE, 10'd0);
    queue_request(OP_ALLOC, 10'd0);        // back to 0
    calm = 0;
    queue_count(11'd0);                    // nothing managed
    queue_request(OP_ALLOC, 10'd5);        // no block
    queue_request(OP_FREE, 10'd2);         // ignored, 2 stays used
    queue_count(11'h7FF);                  // saturates at MAX_BLOCKS
    queue_request(OP_ALLOC, 10'd0);        // 3
    queue_count(11'd5);                    // partial word
    queue_request(OP_ALLOC, 10'd0);        // 4
    queue_request(OP_ALLOC, 10'd0);        // full -> not found
    queue_request(OP_FREE, 10'd4);
    queue_request(OP_ALLOC, 10'd0);        // 4 again
    queue_request(OP_FREE, 10'd7);         // beyond count, ignored
    queue_count(11'd3);                    // shrink below used bits
    queue_request(OP_FREE, 10'd4);         // beyond count, 4 kept used
    queue_request(OP_ALLOC, 10'd0);        // not found
    queue_count(BLOCK_COUNT_RESET);
    queue_request(OP_ALLOC, 10'd0);        // 5, since 4 was kept
    queue_drain();

    // --- random part: phases of one count each ---
    // First phase is allocate-heavy at the full count to push grants deep.
    cnt       = BLOCK_COUNT_RESET;
    alloc_pct = 90;
    phase_len = 150;
    while (requests_queued < 620) begin
      queue_count(cnt);
      calm = ($urandom_range(0, 3) == 0);
      lim  = (cnt > MAX_BLOCKS) ? MAX_BLOCKS : cnt;
      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 99) < alloc_pct)
          queue_request(OP_ALLOC, BLK_W'($urandom));
        else if (lim != 0 && $urandom_range(0, 9) < 8)
          queue_request(OP_FREE, BLK_W'($urandom_range(0, lim - 1)));
        else
          queue_request(OP_FREE, BLK_W'($urandom_range(0, 1023)));
        if (k == phase_len / 2 && $urandom_range(0, 2) == 0)
          queue_drain();
      end
      case ($urandom_range(0, 9))
        0:       cnt = 11'd0;
        1:       cnt = 11'd1;
        2:       cnt = 11'd31;
        3:       cnt = 11'd32;
        4:       cnt = 11'd33;
        5:       cnt = BLOCK_COUNT_RESET;
        6:       cnt = 11'h7FF;
        7:       cnt = CNT_W'($urandom_range(0, 2047));
        default: cnt = CNT_W'($urandom_range(2, 100));
      endcase
      alloc_pct = $urandom_range(30, 75);
      phase_len = $urandom_range(30, 80);
    end
    // leave the last phase with every count bit cleared once more
    queue_count(11'd0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || inflight != 0 || start || cfg_we)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_grants.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_grants.size()));
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
